// ----- rtl/nphit_pkg.sv -----
// Shared types, constants and the distance compare step of the nearest point hit test.
package nphit_pkg;

	// Table size and the widths that follow from it
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Fixed field widths
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int COORD_W  = 11;
	localparam int COUNT_W  = 7;
	localparam int TAP_W    = 10;
	localparam int RAD_W    = 20;
	localparam int SEL_W    = 7;
	localparam int REQ_W    = 16;

	// Tap minus point spans -1023..2047: one bit above the point width
	localparam int DX_W     = COORD_W + 1;
	// Largest square is 2047^2, below 2^22
	localparam int SQ_W     = 2 * DX_W - 2;
	localparam int D2_W     = SQ_W + 1;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1225);
	localparam logic [SEL_W-1:0] NO_SELECTION = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_TAP    = 2'd2
	} kind_t;

	// Point write broadcast to every cell
	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                     named;
	} wr_t;

	// Query word that walks the chain. The squares belong to the previous
	// cell's point and are compared one cell later.
	typedef struct packed {
		logic              valid;
		logic [TAP_W-1:0]  tap_x;
		logic [TAP_W-1:0]  tap_y;
		logic              pend;
		logic [SQ_W-1:0]   sq_x;
		logic [SQ_W-1:0]   sq_y;
		logic [IDX_W-1:0]  pend_idx;
		logic              pend_named;
		logic [RAD_W-1:0]  best_d2;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic              best_named;
	} token_t;

	// Fold the pending distance into the running best; later index wins ties.
	function automatic token_t settle(token_t t);
		token_t           r;
		logic [D2_W-1:0]  d2;
		r  = t;
		d2 = D2_W'(t.sq_x) + D2_W'(t.sq_y);
		if (t.pend && (d2 <= D2_W'(t.best_d2))) begin
			r.best_d2    = RAD_W'(d2);
			r.found      = 1'b1;
			r.best_idx   = t.pend_idx;
			r.best_named = t.pend_named;
		end
		r.pend = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/nphit_cell.sv -----
// One table cell: holds a point and advances the query word by one slot.
module nphit_cell (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [nphit_pkg::IDX_W-1:0]             cell_index,
	input  logic [nphit_pkg::CNT_W-1:0]             active_count,
	input  nphit_pkg::wr_t                          wr,
	input  nphit_pkg::token_t                       tok_in,
	output nphit_pkg::token_t                       tok_out
);

	logic signed [nphit_pkg::COORD_W-1:0] px_q;
	logic signed [nphit_pkg::COORD_W-1:0] py_q;
	logic                                 named_q;

	logic signed [nphit_pkg::DX_W-1:0]    dx;
	logic signed [nphit_pkg::DX_W-1:0]    dy;
	logic signed [2*nphit_pkg::DX_W-1:0]  dxx;
	logic signed [2*nphit_pkg::DX_W-1:0]  dyy;

	nphit_pkg::token_t tok_mid;
	nphit_pkg::token_t tok_nxt;
	nphit_pkg::token_t tok_q;
	logic              valid_q;

	// Store the point when the write targets this slot
	always_ff @(posedge clk) begin
		if (wr.en && (wr.slot == cell_index)) begin
			px_q    <= wr.x;
			py_q    <= wr.y;
			named_q <= wr.named;
		end
	end

	always_comb begin
		tok_mid = nphit_pkg::settle(tok_in);
		dx  = $signed({2'b00, tok_in.tap_x}) - $signed({px_q[nphit_pkg::COORD_W-1], px_q});
		dy  = $signed({2'b00, tok_in.tap_y}) - $signed({py_q[nphit_pkg::COORD_W-1], py_q});
		dxx = dx * dx;
		dyy = dy * dy;
		tok_nxt            = tok_mid;
		tok_nxt.pend       = tok_in.valid &&
			(nphit_pkg::CNT_W'(cell_index) < active_count);
		tok_nxt.sq_x       = nphit_pkg::SQ_W'(unsigned'(dxx));
		tok_nxt.sq_y       = nphit_pkg::SQ_W'(unsigned'(dyy));
		tok_nxt.pend_idx   = cell_index;
		tok_nxt.pend_named = named_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

// ----- rtl/nearest_point_hit_test_core.sv -----
// Top level of the nearest point hit test: control, chain of cells and result word.
//
// Holds up to MAX_POINTS (64) screen points, one per cell in a chain, and
// answers three kinds of input word, selected by s_tuser. A write stores one
// point into its cell and a commit sets how many points are in use and
// clears the selection; both return their result word in the cycle after
// acceptance. A tap launches a query word into cell 0; each cell squares the
// distance from the tap to its own point and hands it to the next cell,
// which folds it into the running best (squared distance at most
// hit_radius_squared, later index winning ties). The word passes through
// every cell's register in turn; the last point is settled as it leaves the
// last cell and the tap result is registered into the output register, so
// the time to the result depends on the chain length, not the point count. One
// tap is in flight at a time; s_tready stays low while it walks the chain.
// A hit on a named point raises lookup_request and bumps the wrapping
// 16-bit request counter. The result waits in an output register, and the
// next input word may be accepted in the cycle it is taken. Tapping a slot
// below the committed count that was never written gives an undefined
// result. The user must write the radius register through cfg_we / cfg_wdata
// only while the block is idle (not enforced); it resets to 1225 (35 pixels).
module nearest_point_hit_test_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Radius register write
	input  logic                                  cfg_we,
	input  logic [nphit_pkg::RAD_W-1:0]           cfg_wdata,
	// Input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// entry_index[5:0], point_x[16:6], point_y[27:17], point_named[28],
	// point_count[35:29], tap_x[45:36], tap_y[55:46]
	input  logic [nphit_pkg::IN_DATA_W-1:0]       s_tdata,
	// kind[1:0]
	input  logic [nphit_pkg::KIND_W-1:0]          s_tuser,
	// Result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// selected_index[6:0], hit[7], lookup_request[8], request_count[24:9],
	// zero fill [31:25]
	output logic [nphit_pkg::OUT_DATA_W-1:0]      m_tdata
);

	// Input fields
	logic [nphit_pkg::SLOT_W-1:0]          entry_index;
	logic signed [nphit_pkg::COORD_W-1:0]  point_x;
	logic signed [nphit_pkg::COORD_W-1:0]  point_y;
	logic                                  point_named;
	logic [nphit_pkg::COUNT_W-1:0]         point_count;
	logic [nphit_pkg::TAP_W-1:0]           tap_x;
	logic [nphit_pkg::TAP_W-1:0]           tap_y;
	nphit_pkg::kind_t                      kind;

	assign entry_index = s_tdata[5:0];
	assign point_x     = s_tdata[16:6];
	assign point_y     = s_tdata[27:17];
	assign point_named = s_tdata[28];
	assign point_count = s_tdata[35:29];
	assign tap_x       = s_tdata[45:36];
	assign tap_y       = s_tdata[55:46];
	assign kind        = nphit_pkg::kind_t'(s_tuser);

	// State
	logic [nphit_pkg::RAD_W-1:0]  radius_q;
	logic [nphit_pkg::CNT_W-1:0]  active_count_q;
	logic [nphit_pkg::SEL_W-1:0]  selection_q;
	logic [nphit_pkg::REQ_W-1:0]  req_count_q;
	logic                         busy_q;

	// Result register
	logic                         out_valid_q;
	logic [nphit_pkg::SEL_W-1:0]  out_sel_q;
	logic                         out_hit_q;
	logic                         out_lookup_q;
	logic [nphit_pkg::REQ_W-1:0]  out_req_q;

	logic                         accept;
	logic                         slot_ok;
	nphit_pkg::wr_t               wr;
	nphit_pkg::token_t            launch;
	nphit_pkg::token_t            chain [nphit_pkg::MAX_POINTS+1];
	nphit_pkg::token_t            fin;
	logic                         fin_valid;
	logic [nphit_pkg::SEL_W-1:0]  fin_sel;
	logic                         fin_lookup;

	// Take a word only when no tap is walking and the result slot frees up
	assign s_tready = !busy_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Drop writes to slots past the table
	assign slot_ok = 32'(entry_index) < nphit_pkg::MAX_POINTS;

	always_comb begin
		wr.en    = accept && (kind == nphit_pkg::KIND_WRITE) && slot_ok;
		wr.slot  = nphit_pkg::IDX_W'(entry_index);
		wr.x     = point_x;
		wr.y     = point_y;
		wr.named = point_named;
	end

	// Launch word for cell 0: best starts at the radius, nothing pending
	always_comb begin
		launch            = '0;
		launch.valid      = accept && (kind == nphit_pkg::KIND_TAP);
		launch.tap_x      = tap_x;
		launch.tap_y      = tap_y;
		launch.best_d2    = radius_q;
	end

	assign chain[0] = launch;

	for (genvar i = 0; i < nphit_pkg::MAX_POINTS; i++) begin : g_cell
		nphit_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_index   (nphit_pkg::IDX_W'(i)),
			.active_count (active_count_q),
			.wr           (wr),
			.tok_in       (chain[i]),
			.tok_out      (chain[i+1])
		);
	end

	// Settle the last cell's point, then form the tap result
	always_comb begin
		fin        = nphit_pkg::settle(chain[nphit_pkg::MAX_POINTS]);
		fin_valid  = chain[nphit_pkg::MAX_POINTS].valid;
		fin_sel    = fin.found ? nphit_pkg::SEL_W'(fin.best_idx) : nphit_pkg::NO_SELECTION;
		fin_lookup = fin.found && fin.best_named;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= nphit_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Control and selection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
			selection_q    <= nphit_pkg::NO_SELECTION;
			req_count_q    <= '0;
			busy_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				unique case (kind)
					nphit_pkg::KIND_WRITE: begin
						out_valid_q <= 1'b1;
					end
					nphit_pkg::KIND_COMMIT: begin
						active_count_q <= (32'(point_count) > nphit_pkg::MAX_POINTS) ?
							nphit_pkg::CNT_W'(nphit_pkg::MAX_POINTS) :
							nphit_pkg::CNT_W'(point_count);
						selection_q    <= nphit_pkg::NO_SELECTION;
						out_valid_q    <= 1'b1;
					end
					nphit_pkg::KIND_TAP: begin
						busy_q <= 1'b1;
					end
					default: begin
						out_valid_q <= 1'b1;
					end
				endcase
			end
			if (fin_valid) begin
				busy_q      <= 1'b0;
				selection_q <= fin_sel;
				out_valid_q <= 1'b1;
				if (fin_lookup) begin
					req_count_q <= req_count_q + 1'b1;
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept && (kind != nphit_pkg::KIND_TAP)) begin
			out_sel_q    <= (kind == nphit_pkg::KIND_COMMIT) ?
				nphit_pkg::NO_SELECTION : selection_q;
			out_hit_q    <= 1'b0;
			out_lookup_q <= 1'b0;
			out_req_q    <= req_count_q;
		end else if (fin_valid) begin
			out_sel_q    <= fin_sel;
			out_hit_q    <= fin.found;
			out_lookup_q <= fin_lookup;
			out_req_q    <= fin_lookup ? (req_count_q + 1'b1) : req_count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_req_q, out_lookup_q, out_hit_q, out_sel_q};

endmodule
